/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

/* rtl/core/mexp_pkg.sv */
// ---------------------------------------------------------------------------
// mexp_pkg
// Widths, reset constant and shared types of the modular exponentiator.
// ---------------------------------------------------------------------------
package mexp_pkg;

    // Operand width
    localparam int DATA_BITS = 63;
    // Width of a count that can hold DATA_BITS itself
    localparam int CNT_BITS  = $clog2(DATA_BITS + 1);

    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    typedef logic [DATA_BITS-1:0] data_t;
    // One extra bit for a sum or a doubled value
    typedef logic [DATA_BITS:0]   wide_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    // Status of an arithmetic unit towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mexp_unit_stat_t;

endpackage

/* rtl/core/modular_exponentiation.sv */
// ---------------------------------------------------------------------------
// modular_exponentiation
// base_value ^ exponent_value mod modulus, right-to-left square-and-multiply.
// ---------------------------------------------------------------------------
// One item at a time. The base is first reduced modulo the modulus. Then
// each exponent bit, up to the highest set one, costs one pass of the
// bit-serial modular multipliers: the square and the conditional multiply
// run side by side, each taking one bit of its multiplier per cycle up to
// that operand's highest set bit; the multiplier loop sets the rate. A
// modulus of 0 or 1 gives 0 without the reduction or a multiplier pass.
// in_ready is high when the sequencer is idle; a finished item waits in the
// output register while the next item is taken. The modulus must only be
// written while idle.
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    // Configuration
    input  logic  modulus_wr_en,
    input  data_t modulus_wr_data,
    // Input items
    input  logic  in_valid,
    output logic  in_ready,
    input  data_t base_value,
    input  data_t exponent_value,
    // Result items
    output logic  out_valid,
    input  logic  out_ready,
    output data_t power_result
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_LOOP,
        S_MUL,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    data_t modulus_reg;
    data_t base_reg, base_next;
    data_t exp_reg, exp_next;
    data_t sq_reg, sq_next;
    data_t acc_reg, acc_next;
    data_t res_reg, res_next;
    data_t out_data_reg, out_data_next;
    logic  out_valid_reg, out_valid_next;
    logic  red_start_reg, red_start_next;
    logic  sq_start_reg, sq_start_next;
    logic  mul_start_reg, mul_start_next;

    data_t           red_result;
    data_t           sq_result;
    data_t           mul_result;
    mexp_unit_stat_t red_stat;
    mexp_unit_stat_t sq_stat;
    mexp_unit_stat_t mul_stat;

    logic in_fire;

    // Arithmetic units
    mexp_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (red_start_reg),
        .value     (base_reg),
        .modulus   (modulus_reg),
        .remainder (red_result),
        .stat      (red_stat)
    );

    mexp_mulmod u_square (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start_reg),
        .op_a    (sq_reg),
        .op_b    (sq_reg),
        .modulus (modulus_reg),
        .product (sq_result),
        .stat    (sq_stat)
    );

    mexp_mulmod u_multiply (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .op_a    (acc_reg),
        .op_b    (sq_reg),
        .modulus (modulus_reg),
        .product (mul_result),
        .stat    (mul_stat)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        red_start_next = 1'b0;
        sq_start_next  = 1'b0;
        mul_start_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    base_next = base_value;
                    exp_next  = exponent_value;
                    acc_next  = DATA_BITS'(1);
                    if (modulus_reg <= DATA_BITS'(1))
                    begin
                        res_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        red_start_next = 1'b1;
                        state_next     = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (red_stat.done)
                begin
                    sq_next    = red_result;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (exp_reg == '0)
                begin
                    res_next   = acc_reg;
                    state_next = S_FINISH;
                end
                else
                begin
                    sq_start_next  = 1'b1;
                    mul_start_next = exp_reg[0];
                    state_next     = S_MUL;
                end
            end
            S_MUL:
            begin
                // Both units idle once the start pulse has been seen
                if (!sq_start_reg && !sq_stat.busy && !mul_stat.busy)
                begin
                    sq_next = sq_result;
                    if (exp_reg[0])
                    begin
                        acc_next = mul_result;
                    end
                    exp_next   = exp_reg >> 1;
                    state_next = S_LOOP;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            red_start_reg <= 1'b0;
            sq_start_reg  <= 1'b0;
            mul_start_reg <= 1'b0;
            modulus_reg   <= data_t'(MODULUS_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            red_start_reg <= red_start_next;
            sq_start_reg  <= sq_start_next;
            mul_start_reg <= mul_start_next;
            if (modulus_wr_en)
            begin
                modulus_reg <= modulus_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        exp_reg      <= exp_next;
        sq_reg       <= sq_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign power_result = out_data_reg;

    // Checks
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready)
    `ASSERT_IMPLIES(a_square_in_mul, clk, rst_n, sq_stat.busy, state_reg == S_MUL)
    `ASSERT_IMPLIES(a_mul_in_mul, clk, rst_n, mul_stat.busy || mul_stat.done, state_reg == S_MUL)
    `ASSERT_IMPLIES(a_reduce_done, clk, rst_n, red_stat.done, state_reg == S_REDUCE)

endmodule

/* rtl/core/mexp_mulmod.sv */
// ---------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial shift-and-add modular multiplier: (a * b) mod m, a and b < m.
// One multiplier bit per cycle, least significant first; stops when the
// remaining multiplier bits are all zero.
// ---------------------------------------------------------------------------
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  data_t           op_a,
    input  data_t           op_b,
    input  data_t           modulus,
    output data_t           product,
    output mexp_unit_stat_t stat
);

    data_t acc_reg, acc_next;
    data_t a_reg, a_next;
    data_t b_reg, b_next;
    logic  busy_reg, busy_next;
    logic  done_reg, done_next;

    wide_t sum_acc;
    wide_t dbl_a;
    wide_t mod_w;

    // Add and double, each reduced by one conditional subtract
    always_comb
    begin
        mod_w   = {1'b0, modulus};
        sum_acc = {1'b0, acc_reg} + {1'b0, a_reg};
        dbl_a   = {a_reg, 1'b0};

        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = (sum_acc >= mod_w) ? DATA_BITS'(sum_acc - mod_w)
                                                  : DATA_BITS'(sum_acc);
                end
                a_next = (dbl_a >= mod_w) ? DATA_BITS'(dbl_a - mod_w)
                                          : DATA_BITS'(dbl_a);
                b_next = b_reg >> 1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/core/mexp_reduce.sv */
// ---------------------------------------------------------------------------
// mexp_reduce
// Bit-serial reduction x mod m, most significant bit first (Horner form):
// r = 2r + bit, then one conditional subtract, for each of the DATA_BITS bits.
// ---------------------------------------------------------------------------
module mexp_reduce
    import mexp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  data_t           value,
    input  data_t           modulus,
    output data_t           remainder,
    output mexp_unit_stat_t stat
);

    data_t r_reg, r_next;
    data_t x_reg, x_next;
    cnt_t  cnt_reg, cnt_next;
    logic  busy_reg, busy_next;
    logic  done_reg, done_next;

    wide_t shifted;
    wide_t mod_w;

    // One remainder bit per cycle
    always_comb
    begin
        mod_w   = {1'b0, modulus};
        shifted = {r_reg, x_reg[DATA_BITS-1]};

        r_next    = r_reg;
        x_next    = x_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            r_next    = '0;
            x_next    = value;
            cnt_next  = CNT_BITS'(DATA_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                r_next   = (shifted >= mod_w) ? DATA_BITS'(shifted - mod_w)
                                              : DATA_BITS'(shifted);
                x_next   = x_reg << 1;
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        x_reg <= x_next;
    end

    assign remainder = r_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* dv/modular_exponentiation_checker.sv */
// ---------------------------------------------------------------------------
// modular_exponentiation_checker
// Watches the modulus port and both item channels of the exponentiator,
// works out base ^ exponent mod modulus for every accepted item and checks
// each returned power against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module modular_exponentiation_checker
    import mexp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  modulus_wr_en,
    input  data_t modulus_wr_data,
    input  logic  in_valid,
    input  logic  in_ready,
    input  data_t base_value,
    input  data_t exponent_value,
    input  logic  out_valid,
    input  logic  out_ready,
    input  data_t power_result,
    output int    mismatch_count,
    output int    pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // Own copy of the modulus register
    data_t modulus_copy;
    // Predicted powers, oldest first
    data_t expected_powers[$];

    // Shift-and-add (a * b) mod m; a and b already below m, so a doubled
    // value or a sum never needs more than one extra bit
    function automatic data_t mulmod(input data_t a_in, input data_t b_in,
                                     input data_t m);
        wide_t a;
        wide_t acc;
        wide_t mw;
        data_t b;
        a   = {1'b0, a_in};
        acc = '0;
        mw  = {1'b0, m};
        b   = b_in;
        while (b != '0)
        begin
            if (b[0])
            begin
                acc = acc + a;
                if (acc >= mw)
                    acc = acc - mw;
            end
            a = a + a;
            if (a >= mw)
                a = a - mw;
            b = b >> 1;
        end
        return acc[DATA_BITS-1:0];
    endfunction

    // Right-to-left square and multiply; modulus 0 or 1 gives 0
    function automatic data_t powmod(input data_t base_in, input data_t exp_in,
                                     input data_t m);
        data_t sq;
        data_t acc;
        data_t e;
        if (m <= data_t'(1))
            return '0;
        sq  = base_in % m;
        acc = data_t'(1);
        e   = exp_in;
        while (e != '0)
        begin
            if (e[0])
                acc = mulmod(acc, sq, m);
            sq = mulmod(sq, sq, m);
            e  = e >> 1;
        end
        return acc;
    endfunction

    assign pending_results = expected_powers.size();

    // Predict on input items, compare on result items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_copy <= MODULUS_RESET[DATA_BITS-1:0];
            expected_powers.delete();
            mismatch_count <= 0;
        end
        else
        begin
            if (modulus_wr_en)
                modulus_copy <= modulus_wr_data;
            if (in_valid && in_ready)
                expected_powers.insert(expected_powers.size(),
                                       powmod(base_value, exponent_value,
                                              modulus_copy));
            if (out_valid && out_ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("power_result: no item outstanding, got %0d",
                           power_result);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    if (power_result !== expected_powers[0])
                    begin
                        $error("power_result: expected %0d, got %0d",
                               expected_powers[0], power_result);
                        mismatch_count <= mismatch_count + 1;
                    end
                    void'(expected_powers.pop_front());
                end
            end
        end
    end

endmodule

/* dv/modular_exponentiation_tb.sv */
// ---------------------------------------------------------------------------
// modular_exponentiation_tb
// Drives the exponentiator with directed corner items under several moduli
// (reset value, 1, 0, 2, all ones), then random items in four phases with
// different idling on both channels and a fresh modulus per phase. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ---------------------------------------------------------------------------
module modular_exponentiation_tb;
    import mexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam data_t DATA_MAX        = '1;
    localparam data_t MOD_DEFAULT     = MODULUS_RESET[DATA_BITS-1:0];
    localparam int    ITEMS_PER_PHASE = 30;
    localparam int    NUM_PHASES      = 4;
    // Must exceed the slowest item; leave plenty over for stalls
    localparam int    WATCHDOG_LIMIT  = 40000;

    logic  clk             = 1'b0;
    logic  rst_n           = 1'b0;
    logic  modulus_wr_en   = 1'b0;
    data_t modulus_wr_data = '0;
    logic  in_valid        = 1'b0;
    logic  in_ready;
    data_t base_value      = '0;
    data_t exponent_value  = '0;
    logic  out_valid;
    logic  out_ready       = 1'b0;
    data_t power_result;

    int    mismatch_count;
    int    pending_results;
    int    src_idle_pct    = 0;
    int    sink_stall_pct  = 0;
    int    idle_cycles     = 0;
    data_t current_modulus = MOD_DEFAULT;

    always #10 clk = ~clk;

    modular_exponentiation dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .modulus_wr_en   (modulus_wr_en),
        .modulus_wr_data (modulus_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .base_value      (base_value),
        .exponent_value  (exponent_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .power_result    (power_result)
    );

    modular_exponentiation_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .modulus_wr_en   (modulus_wr_en),
        .modulus_wr_data (modulus_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .base_value      (base_value),
        .exponent_value  (exponent_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .power_result    (power_result),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Result side back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= sink_stall_pct);

    // Watchdog: cycles with no handshake and no register write
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            modulus_wr_en)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic data_t rand_data();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[DATA_BITS-1:0];
    endfunction

    // Ones in the low w bits
    function automatic data_t low_mask(input int w);
        if (w >= DATA_BITS)
            return DATA_MAX;
        return (data_t'(1) << w) - data_t'(1);
    endfunction

    // Random value of exactly w bits (top bit set)
    function automatic data_t rand_width(input int w);
        if (w <= 0)
            return '0;
        return (rand_data() & low_mask(w)) | (data_t'(1) << (w - 1));
    endfunction

    // Entered and left at a falling edge; valid stays high on exit
    task automatic send_power_request(input data_t b, input data_t e);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        base_value     <= b;
        exponent_value <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain everything, then write the modulus while the block is idle
    task automatic write_modulus(input data_t value);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        modulus_wr_en   <= 1'b1;
        modulus_wr_data <= value;
        current_modulus  = value;
        @(negedge clk);
        modulus_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_random_power();
        data_t b;
        data_t e;
        int    ew;
        case ($urandom_range(9))
            6:       b = rand_width($urandom_range(DATA_BITS, 1));
            7:       b = current_modulus - data_t'(1);
            8:       b = current_modulus;
            9:       b = data_t'($urandom_range(1));
            default: b = rand_data();
        endcase
        // Exponent length spread evenly so the run stays short
        ew = $urandom_range(DATA_BITS);
        if ($urandom_range(3) == 0)
            e = rand_width(ew);
        else
            e = rand_data() & low_mask(ew);
        send_power_request(b, e);
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Corner items under the reset modulus
        send_power_request('0, '0);
        send_power_request('0, data_t'(5));
        send_power_request(DATA_MAX, DATA_MAX);
        send_power_request(DATA_MAX, '0);
        send_power_request(data_t'(1), DATA_MAX);
        send_power_request(MOD_DEFAULT, data_t'(7));
        send_power_request(MOD_DEFAULT - data_t'(1), data_t'(2));
        send_power_request(data_t'(2), data_t'(1) << (DATA_BITS - 1));
        send_power_request(DATA_BITS'({(DATA_BITS+1)/2{2'b01}}),
                           DATA_BITS'({(DATA_BITS+1)/2{2'b10}}));
        send_power_request(DATA_BITS'({(DATA_BITS+1)/2{2'b10}}),
                           DATA_BITS'({(DATA_BITS+1)/2{2'b01}}));
        send_power_request(data_t'(3), data_t'(1));

        // Modulus one: always 0, exponent zero included
        write_modulus(data_t'(1));
        send_power_request(data_t'(5), '0);
        send_power_request(DATA_MAX, DATA_MAX);

        // Modulus zero
        write_modulus('0);
        send_power_request(data_t'(7), '0);
        send_power_request(DATA_MAX, data_t'(3));

        // Smallest useful modulus
        write_modulus(data_t'(2));
        send_power_request(DATA_MAX, DATA_MAX);
        send_power_request(data_t'(4), '0);
        send_power_request(data_t'(4), data_t'(9));

        // Largest modulus
        write_modulus(DATA_MAX);
        send_power_request(DATA_MAX, data_t'(5));
        send_power_request(DATA_MAX - data_t'(1), DATA_MAX);
        send_power_request(data_t'(1) << (DATA_BITS - 1), data_t'(2));
        send_power_request(data_t'(2), data_t'(DATA_BITS - 1));

        // Random phases: no idling, sender idle, receiver stalls, both light
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: write_modulus(rand_width(DATA_BITS));
                1: write_modulus(rand_width($urandom_range(20, 2)));
                2: write_modulus(rand_width($urandom_range(DATA_BITS - 1, 21)));
                default: write_modulus(rand_data());
            endcase
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 65;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 65;
                end
                default:
                begin
                    src_idle_pct   = 7;
                    sink_stall_pct = 7;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_power();
        end

        // Drain and let any stray result show up
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/mexp_pkg.sv
rtl/core/mexp_mulmod.sv
rtl/core/mexp_reduce.sv
rtl/core/modular_exponentiation.sv
dv/modular_exponentiation_checker.sv
dv/modular_exponentiation_tb.sv
